// File: rtl/clipped_image_blit_converter_assert.svh
// Assertion macros used by the checker file of the blit converter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CLIPPED_IMAGE_BLIT_CONVERTER_ASSERT_SVH
`define CLIPPED_IMAGE_BLIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define CIBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CIBC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cibc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_pkg
// Shared types, constants and the pixel format conversion of the blit
// converter.
// ----------------------------------------------------------------------------
package cibc_pkg;

	localparam int MAX_DIM_DEF     = 2048;
	localparam int BYTES_PER_PIXEL = 4;

	localparam int PIXEL_W  = 24;
	localparam int ADDR_W   = 25;
	localparam int POS_W    = 11;
	localparam int DIM_W    = 12;
	localparam int STRIDE_W = 14;
	localparam int FMT_W    = 2;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [4:0] B5_MASK = 5'h1f;
	localparam logic [5:0] G6_MASK = 6'h3f;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SRC_WIDTH     = 3'd2,
		REG_SRC_HEIGHT    = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5,
		REG_ROW_STRIDE    = 3'd6,
		REG_PIXEL_FORMAT  = 3'd7
	} reg_idx_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_GRAY   = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_RGB888 = 2'd2
	} pixel_fmt_t;

	typedef struct packed {
		logic [POS_W-1:0]    dest_x;
		logic [POS_W-1:0]    dest_y;
		logic [DIM_W-1:0]    src_width;
		logic [DIM_W-1:0]    src_height;
		logic [DIM_W-1:0]    screen_width;
		logic [DIM_W-1:0]    screen_height;
		logic [STRIDE_W-1:0] row_stride;
		logic [FMT_W-1:0]    pixel_format;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] src_pixel;
		logic               frame_start;
	} in_word_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  byte_address;
		logic [PIXEL_W-1:0] pixel_word;
		logic               frame_last;
	} out_word_t;

	// Pixel data and end-of-image flag carried through the input stage.
	typedef struct packed {
		logic [PIXEL_W-1:0] src_pixel;
		logic               frame_last;
	} stage_t;

	function automatic logic [PIXEL_W-1:0] convert_pixel(
		input logic [PIXEL_W-1:0] p,
		input logic [FMT_W-1:0]   fmt
	);
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		b = '0;
		g = '0;
		r = '0;
		case (fmt)
			FMT_GRAY: begin
				b = p[7:0];
				g = p[7:0];
				r = p[7:0];
			end
			FMT_RGB565: begin
				b = {p[4:0] & B5_MASK, 3'b000};
				g = {p[10:5] & G6_MASK, 2'b00};
				r = {p[15:11] & B5_MASK, 3'b000};
			end
			default: begin
				// RGB888 and the unused code pass the bytes through
				b = p[7:0];
				g = p[15:8];
				r = p[23:16];
			end
		endcase
		return {r, g, b};
	endfunction

endpackage

// File: rtl/clipped_image_blit_converter.sv
`timescale 1ns / 1ps
// Flow: an accepted word passes the input stage register, then the output register.
// Throughput: one word per clock while out_ready is high; the counter update and
// the one multiplier of the address path each sit between a pair of registers.
// Reset: arst_n clears the counters, both stage valids and loads the register
// reset values (image and screen size 1, format RGB565, others 0).
// ----------------------------------------------------------------------------
// clipped_image_blit_converter
// Converts a raster stream of source pixels into clipped framebuffer writes.
// ----------------------------------------------------------------------------
module clipped_image_blit_converter #(
	parameter int MAX_DIM = cibc_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cibc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [cibc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cibc_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output cibc_pkg::out_word_t               out_word
);
	import cibc_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIM);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic             take_s1;
	stage_t           stage_s1;
	logic [CNT_W-1:0] col_s1;
	logic [CNT_W-1:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.src_width     <= DIM_W'(1);
			cfg_q.src_height    <= DIM_W'(1);
			cfg_q.screen_width  <= DIM_W'(1);
			cfg_q.screen_height <= DIM_W'(1);
			cfg_q.row_stride    <= '0;
			cfg_q.pixel_format  <= FMT_RGB565;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_DEST_X:        cfg_q.dest_x        <= cfg_data[POS_W-1:0];
				REG_DEST_Y:        cfg_q.dest_y        <= cfg_data[POS_W-1:0];
				REG_SRC_WIDTH:     cfg_q.src_width     <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT:    cfg_q.src_height    <= cfg_data[DIM_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[DIM_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[DIM_W-1:0];
				REG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data[STRIDE_W-1:0];
				REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_data[FMT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cibc_pos #(
		.MAX_DIM(MAX_DIM)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.valid_s1 (valid_s1),
		.take_s1  (take_s1),
		.stage_s1 (stage_s1),
		.col_s1   (col_s1),
		.row_s1   (row_s1)
	);

	cibc_pixel #(
		.MAX_DIM(MAX_DIM)
	) u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.take_s1   (take_s1),
		.stage_s1  (stage_s1),
		.col_s1    (col_s1),
		.row_s1    (row_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// File: rtl/cibc_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_pos
// Column and row tracking of the source image and the input stage register.
// ----------------------------------------------------------------------------
module cibc_pos #(
	parameter int MAX_DIM = cibc_pkg::MAX_DIM_DEF,
	localparam int CNT_W = $clog2(MAX_DIM)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cibc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  cibc_pkg::in_word_t in_word,
	output logic              valid_s1,
	input  logic              take_s1,
	output cibc_pkg::stage_t  stage_s1,
	output logic [CNT_W-1:0]  col_s1,
	output logic [CNT_W-1:0]  row_s1
);
	import cibc_pkg::*;

	// Wide enough for the register value and for MAX_DIM itself
	localparam int LW = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
	localparam logic [LW-1:0] DIM_MAX = LW'(MAX_DIM);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_cur;
	logic [CNT_W-1:0] row_cur;
	logic [LW-1:0]    w_last;
	logic [LW-1:0]    h_last;
	logic             col_end;
	logic             row_end;
	logic             accept;

	function automatic logic [LW-1:0] last_index(input logic [DIM_W-1:0] v);
		logic [LW-1:0] v_ext;
		v_ext = LW'(v);
		if (v == '0)
			return '0;
		else if (v_ext > DIM_MAX)
			return DIM_MAX - LW'(1);
		else
			return v_ext - LW'(1);
	endfunction

	assign in_ready = !valid_s1 || take_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		col_cur = in_word.frame_start ? '0 : col_q;
		row_cur = in_word.frame_start ? '0 : row_q;
		w_last  = last_index(cfg.src_width);
		h_last  = last_index(cfg.src_height);
		col_end = LW'(col_cur) >= w_last;
		row_end = LW'(row_cur) >= h_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				// wrap at the last column, and at the last row of the image
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_cur + CNT_W'(1);
				end else begin
					col_q <= col_cur + CNT_W'(1);
					row_q <= row_cur;
				end
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.src_pixel  <= in_word.src_pixel;
			stage_s1.frame_last <= col_end && row_end;
			col_s1              <= col_cur;
			row_s1              <= row_cur;
		end
	end

endmodule

// File: rtl/cibc_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_pixel
// Screen clipping, address arithmetic, format conversion and the output
// register.
// ----------------------------------------------------------------------------
module cibc_pixel #(
	parameter int MAX_DIM = cibc_pkg::MAX_DIM_DEF,
	localparam int CNT_W = $clog2(MAX_DIM)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cibc_pkg::cfg_t     cfg,
	input  logic               valid_s1,
	output logic               take_s1,
	input  cibc_pkg::stage_t   stage_s1,
	input  logic [CNT_W-1:0]   col_s1,
	input  logic [CNT_W-1:0]   row_s1,
	output logic               out_valid,
	input  logic               out_ready,
	output cibc_pkg::out_word_t out_word
);
	import cibc_pkg::*;

	localparam int SX_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int CW   = (SX_W > DIM_W) ? SX_W : DIM_W;
	localparam int PW   = SX_W + STRIDE_W + 1;

	logic [SX_W-1:0]   sx;
	logic [SX_W-1:0]   sy;
	logic              on_screen;
	logic [PW-1:0]     addr_full;
	out_word_t         result;
	logic              out_valid_q;
	out_word_t         out_word_q;

	assign take_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		sx        = SX_W'(cfg.dest_x) + SX_W'(col_s1);
		sy        = SX_W'(cfg.dest_y) + SX_W'(row_s1);
		on_screen = (CW'(sx) < CW'(cfg.screen_width)) && (CW'(sy) < CW'(cfg.screen_height));
		addr_full = PW'(sy) * PW'(cfg.row_stride) + PW'(sx) * PW'(BYTES_PER_PIXEL);
		result.write_enable = on_screen;
		// clipped words carry zero address and data
		result.byte_address = on_screen ? addr_full[ADDR_W-1:0] : '0;
		result.pixel_word   = on_screen ? convert_pixel(stage_s1.src_pixel, cfg.pixel_format)
		                                : '0;
		result.frame_last   = stage_s1.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (take_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1)
			out_word_q <= result;
	end

endmodule

// File: rtl/cibc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_checker
// Port-level checks of the blit converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "clipped_image_blit_converter_assert.svh"

module cibc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input cibc_pkg::in_word_t  in_word,
	input logic                out_valid,
	input logic                out_ready,
	input cibc_pkg::out_word_t out_word
);
	import cibc_pkg::*;

	// A stalled result word holds
	`CIBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled output word changed")

	// A clipped word carries zero address and pixel data
	`CIBC_ASSERT_IMP(a_clip_zero, out_valid && !out_word.write_enable, (out_word.byte_address == '0) && (out_word.pixel_word == '0), "clipped word not zeroed")

	// With the output register empty the input side never stalls
	`CIBC_ASSERT_IMP(a_no_stall, !out_valid, in_ready, "input stalled with empty output")

	// A word accepted while out_ready is high produces a result on out_valid
	`CIBC_ASSERT_NXT(a_flow, in_valid && in_ready && out_ready, ##1 out_valid, "accepted word did not reach the output")

endmodule

bind clipped_image_blit_converter cibc_checker u_cibc_checker (.*);
